[design/dpcr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpcr_pkg: shared types and constants for depth-to-color registration
// Register indexes, status codes and field widths.
// ----------------------------------------------------------------------------
package dpcr_pkg;

  localparam int DEF_IMAGE_WIDTH  = 512;
  localparam int DEF_IMAGE_HEIGHT = 424;
  localparam int DEPTH_LIMIT      = 10000;
  localparam int NUM_REGS         = 8;
  localparam int CFG_IDX_W        = 3;

  typedef enum logic [1:0] {
    ST_VALID   = 2'd0,
    ST_BAD_DEP = 2'd1,
    ST_OUTSIDE = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_SCALE  = 3'd0,
    REG_INV_OFFSET = 3'd1,
    REG_P0_A       = 3'd2,
    REG_P0_B       = 3'd3,
    REG_P1_A       = 3'd4,
    REG_P1_B       = 3'd5,
    REG_P2_A       = 3'd6,
    REG_P2_B       = 3'd7
  } reg_idx_t;

  localparam logic signed [17:0] WORLD_MAX = 18'sd131071;
  localparam logic signed [17:0] WORLD_MIN = -18'sd131072;

  // Saturate floor(v / 2^24) to 18 bits signed.
  function automatic logic signed [17:0] sat_world(input logic signed [63:0] v);
    logic signed [39:0] s;
    begin
      s = v[63:24];
      if (s > 40'sd131071) sat_world = WORLD_MAX;
      else if (s < -40'sd131072) sat_world = WORLD_MIN;
      else sat_world = s[17:0];
    end
  endfunction

endpackage

[design/depth_pixel_color_registration.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_pixel_color_registration: depth pixel to world point and color pixel
// Back-projects a depth pixel, projects it into the color camera and divides.
// ----------------------------------------------------------------------------
// channel | direction | handshake       | payload
// in_     | input     | valid / stall   | pixel_col, pixel_row, depth_mm
// out_    | output    | valid / stall   | status, world_x/y/z, color_col/row
// cfg_    | input     | valid / ready   | index, data (ready always high)
//
// One word per cycle while the output is not stalled; seven arithmetic stages,
// QW bit-per-stage divider stages (QW = quotient width) and the output register.
// The dividers for u and v run side by side. The whole pipe advances when
// the output register is empty or taken; a stall freezes every stage.
// Reset clears valid bits only; configuration registers reset to zero.
// ----------------------------------------------------------------------------
module depth_pixel_color_registration import dpcr_pkg::*; #(
  parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [8:0]  in_pixel_col,
  input  logic [8:0]  in_pixel_row,
  input  logic [15:0] in_depth_mm,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic signed [17:0] out_world_x,
  output logic signed [17:0] out_world_y,
  output logic [13:0] out_world_z,
  output logic [8:0]  out_color_col,
  output logic [8:0]  out_color_row,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int QW    = $clog2(IMAGE_WIDTH > IMAGE_HEIGHT ? IMAGE_WIDTH : IMAGE_HEIGHT);
  localparam int TAG_W = 2 + 18 + 18 + 14;

  logic [63:0] regs_r [NUM_REGS];
  logic en;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) regs_r[i] <= '0;
    end else if (cfg_valid) begin
      regs_r[cfg_index] <= cfg_data;
    end
  end

  function automatic logic signed [31:0] hi(input logic [63:0] r);
    hi = r[63:32];
  endfunction
  function automatic logic signed [31:0] lo(input logic [63:0] r);
    lo = r[31:0];
  endfunction

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // stage 1: col*sx + ox
  logic s1_v_r, s1_bad_r;
  logic signed [42:0] s1_ax_r, s1_ay_r;
  logic [15:0] s1_d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (en) s1_v_r <= in_valid;
    if (en) begin
      s1_bad_r <= (in_depth_mm == 16'd0) || (in_depth_mm >= 16'(DEPTH_LIMIT));
      s1_ax_r  <= $signed({1'b0, in_pixel_col}) * hi(regs_r[REG_INV_SCALE])
                  + 43'(hi(regs_r[REG_INV_OFFSET]));
      s1_ay_r  <= $signed({1'b0, in_pixel_row}) * lo(regs_r[REG_INV_SCALE])
                  + 43'(lo(regs_r[REG_INV_OFFSET]));
      s1_d_r   <= in_depth_mm;
    end
  end

  // stage 2: times depth
  logic s2_v_r, s2_bad_r;
  logic signed [63:0] s2_px_r, s2_py_r;
  logic [15:0] s2_d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (en) s2_v_r <= s1_v_r;
    if (en) begin
      s2_bad_r <= s1_bad_r;
      s2_px_r  <= 64'(s1_ax_r * $signed({1'b0, s1_d_r}));
      s2_py_r  <= 64'(s1_ay_r * $signed({1'b0, s1_d_r}));
      s2_d_r   <= s1_d_r;
    end
  end

  // stage 3: floor and saturate
  logic s3_v_r, s3_bad_r;
  logic signed [17:0] s3_x_r, s3_y_r;
  logic [15:0] s3_d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else if (en) s3_v_r <= s2_v_r;
    if (en) begin
      s3_bad_r <= s2_bad_r;
      s3_x_r   <= sat_world(s2_px_r);
      s3_y_r   <= sat_world(s2_py_r);
      s3_d_r   <= s2_d_r;
    end
  end

  // stage 4: twelve products
  logic s4_v_r, s4_bad_r;
  logic signed [52:0] s4_m_r [3][4];
  logic signed [17:0] s4_x_r, s4_y_r;
  logic [15:0] s4_d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else if (en) s4_v_r <= s3_v_r;
    if (en) begin
      for (int n = 0; n < 3; n++) begin
        s4_m_r[n][0] <= 53'(hi(regs_r[2+2*n]) * s3_x_r);
        s4_m_r[n][1] <= 53'(lo(regs_r[2+2*n]) * s3_y_r);
        s4_m_r[n][2] <= 53'(hi(regs_r[3+2*n]) * $signed({1'b0, s3_d_r, 4'd0}));
        s4_m_r[n][3] <= 53'(lo(regs_r[3+2*n])) <<< 4;
      end
      s4_bad_r <= s3_bad_r;
      s4_x_r   <= s3_x_r;
      s4_y_r   <= s3_y_r;
      s4_d_r   <= s3_d_r;
    end
  end

  // stage 5: row sums
  logic s5_v_r, s5_bad_r;
  logic signed [63:0] s5_h_r [3];
  logic signed [17:0] s5_x_r, s5_y_r;
  logic [15:0] s5_d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s5_v_r <= 1'b0;
    else if (en) s5_v_r <= s4_v_r;
    if (en) begin
      for (int n = 0; n < 3; n++)
        s5_h_r[n] <= 64'(s4_m_r[n][0]) + 64'(s4_m_r[n][1])
                   + 64'(s4_m_r[n][2]) + 64'(s4_m_r[n][3]);
      s5_bad_r <= s4_bad_r;
      s5_x_r   <= s4_x_r;
      s5_y_r   <= s4_y_r;
      s5_d_r   <= s4_d_r;
    end
  end

  // stage 6: sign-normalize against hz
  logic s6_v_r, s6_bad_r, s6_out_r;
  logic [63:0] s6_nx_r, s6_ny_r, s6_dz_r;
  logic signed [17:0] s6_x_r, s6_y_r;
  logic [15:0] s6_d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s6_v_r <= 1'b0;
    else if (en) s6_v_r <= s5_v_r;
    if (en) begin
      s6_nx_r  <= s5_h_r[2][63] ? 64'(-s5_h_r[0]) : s5_h_r[0];
      s6_ny_r  <= s5_h_r[2][63] ? 64'(-s5_h_r[1]) : s5_h_r[1];
      s6_dz_r  <= s5_h_r[2][63] ? 64'(-s5_h_r[2]) : s5_h_r[2];
      s6_out_r <= (s5_h_r[2] == 64'sd0);
      s6_bad_r <= s5_bad_r;
      s6_x_r   <= s5_x_r;
      s6_y_r   <= s5_y_r;
      s6_d_r   <= s5_d_r;
    end
  end

  // stage 7: range tests  0 < n < lim*den  (values kept in 77 bits)
  logic s7_v_r, s7_bad_r, s7_out_r;
  logic [63:0] s7_nx_r, s7_ny_r, s7_dz_r;
  logic signed [17:0] s7_x_r, s7_y_r;
  logic [15:0] s7_d_r;
  logic signed [76:0] nxe, nye, lwx, lwy;
  always_comb begin
    nxe = 77'($signed(s6_nx_r));
    nye = 77'($signed(s6_ny_r));
    lwx = 77'(s6_dz_r) * 77'(IMAGE_WIDTH);
    lwy = 77'(s6_dz_r) * 77'(IMAGE_HEIGHT);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s7_v_r <= 1'b0;
    else if (en) s7_v_r <= s6_v_r;
    if (en) begin
      s7_out_r <= s6_out_r || nxe <= 0 || nxe >= lwx || nye <= 0 || nye >= lwy;
      s7_nx_r  <= s6_nx_r;
      s7_ny_r  <= s6_ny_r;
      s7_dz_r  <= s6_dz_r;
      s7_bad_r <= s6_bad_r;
      s7_x_r   <= s6_x_r;
      s7_y_r   <= s6_y_r;
      s7_d_r   <= s6_d_r;
    end
  end

  // dividers: out-of-range items divide garbage and are masked afterward
  logic [TAG_W-1:0] tag_in, tag_x, tag_y;
  logic [QW-1:0] qx, qy;
  logic dvx, dvy;
  logic [1:0] st_in;
  assign st_in  = s7_bad_r ? ST_BAD_DEP : (s7_out_r ? ST_OUTSIDE : ST_VALID);
  assign tag_in = {st_in, s7_x_r, s7_y_r, s7_d_r[13:0]};

  dpcr_divider #(.NUM_W(64), .QW(QW), .TAG_W(TAG_W)) u_div_x (
    .clk, .rst_n, .en,
    .in_valid(s7_v_r), .in_num(s7_nx_r), .in_den(s7_dz_r), .in_tag(tag_in),
    .out_valid(dvx), .out_quo(qx), .out_tag(tag_x)
  );
  dpcr_divider #(.NUM_W(64), .QW(QW), .TAG_W(1)) u_div_y (
    .clk, .rst_n, .en,
    .in_valid(s7_v_r), .in_num(s7_ny_r), .in_den(s7_dz_r), .in_tag(1'b0),
    .out_valid(dvy), .out_quo(qy), .out_tag(tag_y[0])
  );
  assign tag_y[TAG_W-1:1] = '0;

  // output register
  logic [1:0] st_o;
  assign st_o = tag_x[TAG_W-1 -: 2];
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (en) out_valid <= dvx;
    if (en) begin
      out_status    <= st_o;
      out_world_x   <= (st_o == ST_BAD_DEP) ? '0 : tag_x[49:32];
      out_world_y   <= (st_o == ST_BAD_DEP) ? '0 : tag_x[31:14];
      out_world_z   <= (st_o == ST_BAD_DEP) ? '0 : tag_x[13:0];
      out_color_col <= (st_o == ST_VALID) ? 9'(qx) : '0;
      out_color_row <= (st_o == ST_VALID) ? 9'(qy) : '0;
    end
  end

`ifndef SYNTHESIS
  a_div_sync: assert property (@(posedge clk) disable iff (!rst_n)
    dvx == dvy) else $error("divider lanes out of step");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status))
    else $error("stalled word changed");
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_BAD_DEP |-> out_world_z == 14'd0)
    else $error("invalid depth word not cleared");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall)) else $error("stall mismatch");
`endif

endmodule

[design/dpcr_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpcr_divider: pipelined restoring divider
// One quotient bit per stage, an item can enter every cycle while en is high. Carries a tag.
// ----------------------------------------------------------------------------
module dpcr_divider import dpcr_pkg::*; #(
  parameter int NUM_W = 64,
  parameter int QW    = 13,
  parameter int TAG_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] in_num,
  input  logic [NUM_W-1:0] in_den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [QW-1:0]    out_quo,
  output logic [TAG_W-1:0] out_tag
);

  logic             v_r   [QW+1];
  logic [NUM_W-1:0] rem_r [QW+1];
  logic [NUM_W-1:0] den_r [QW+1];
  logic [QW-1:0]    quo_r [QW+1];
  logic [TAG_W-1:0] tag_r [QW+1];

  always_comb begin
    v_r[0]   = in_valid;
    rem_r[0] = in_num;
    den_r[0] = in_den;
    quo_r[0] = '0;
    tag_r[0] = in_tag;
  end

  // Quotient is known to be below 2^QW, so test den << (QW-1-k) per stage.
  for (genvar k = 0; k < QW; k++) begin : g_st
    logic [NUM_W+QW-1:0] sh;
    logic                ge;
    assign sh = {{QW{1'b0}}, den_r[k]} << (QW - 1 - k);
    assign ge = {{QW{1'b0}}, rem_r[k]} >= sh;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
      if (en) begin
        rem_r[k+1] <= ge ? rem_r[k] - sh[NUM_W-1:0] : rem_r[k];
        den_r[k+1] <= den_r[k];
        quo_r[k+1] <= quo_r[k] | (QW'(ge) << (QW - 1 - k));
        tag_r[k+1] <= tag_r[k];
      end
    end
  end

  assign out_valid = v_r[QW];
  assign out_quo   = quo_r[QW];
  assign out_tag   = tag_r[QW];

endmodule
